// ----- hdl/fifo_replacement_id_set_macros.svh -----
// Assertion macros shared by the ID set RTL.
// No dependencies; included by the controller and datapath files.
`ifndef FIFO_REPLACEMENT_ID_SET_MACROS_SVH
`define FIFO_REPLACEMENT_ID_SET_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define FRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("frs assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("frs assertion failed");

`endif

// ----- hdl/frs_pkg.sv -----
// Shared types and constants for the FIFO-replacement ID set.
// No dependencies.
package frs_pkg;

  localparam int CAP_W    = 5;
  localparam int CAP_RST  = 16;
  localparam int IN_ID_W  = 32;
  localparam int OUT_ID_W = 32;
  localparam int CNT_W    = 5;
  localparam int OUT_DW   = 72;
  localparam int OUT_UW   = 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_EVICT,
    S_LIST_RD,
    S_LIST_OUT,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    OSEL_HIT,
    OSEL_MISS,
    OSEL_EMPTY,
    OSEL_LIST
  } out_sel_e;

  typedef struct packed {
    logic     capture;
    logic     append;
    logic     evict;
    logic     rd_oldest;
    logic     rd_list;
    logic     idx_clr;
    logic     idx_inc;
    logic     out_ld;
    out_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic is_list;
    logic hit;
    logic occ_zero;
    logic need_evict;
    logic list_last;
  } sts_t;

endpackage

// ----- hdl/fifo_replacement_id_set.sv -----
// Top level of the FIFO-replacement ID set: stream ports, controller, datapath.
// Depends on frs_pkg, frs_ctrl, frs_dp (and frs_ram below it).
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata sender_id, tuser action
//  m_axis   | out       | m_axis_tvalid/tready    | tdata ids+count, tuser flags, tlast
//  cfg      | in        | cfg_we_i (no wait)      | cfg_wdata_i capacity
//
// A message item passes S_LOOKUP then S_OUT (S_LOOKUP, S_EVICT, S_OUT on an eviction);
// its result is registered, on an eviction from the registered RAM read.
// A list item passes S_LOOKUP, then S_LIST_RD and S_LIST_OUT for each of N > 0 held
// entries, one RAM read per entry, or S_LOOKUP and S_OUT on an empty set.
// One item is in flight at a time; a stalled result holds until taken.
// Reset clears occupancy, oldest pointer, entry valid bits and sets capacity to 16.
module fifo_replacement_id_set
  import frs_pkg::*;
#(
  parameter int DEPTH    = 16,
  parameter int ID_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CAP_W-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IN_ID_W-1:0]  s_axis_tdata,  // [31:0] sender_id
  input  logic                s_axis_tuser,  // [0] action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_DW-1:0]   m_axis_tdata,  // [31:0] evicted_id, [63:32] listed_id,
                                             // [68:64] held_count, [71:69] zero
  output logic [OUT_UW-1:0]   m_axis_tuser,  // [0] was_present, [1] evicted_valid,
                                             // [2] listed_valid
  output logic                m_axis_tlast   // last
);

  cmd_t cmd;
  sts_t sts;

  frs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  frs_dp #(
    .DEPTH   (DEPTH),
    .ID_WIDTH(ID_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_action_i   (s_axis_tuser),
    .in_sender_id_i(s_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_tdata_o   (m_axis_tdata),
    .out_tuser_o   (m_axis_tuser),
    .out_tlast_o   (m_axis_tlast)
  );

endmodule

// ----- hdl/frs_ram.sv -----
// Generic single-port-write, registered-read RAM.
// No dependencies.
module frs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/frs_ctrl.sv -----
// Controller FSM for the ID set: sequences lookup, eviction and listing.
// Depends on frs_pkg and fifo_replacement_id_set_macros.svh.
`include "fifo_replacement_id_set_macros.svh"

module frs_ctrl
  import frs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (sts_i.is_list) begin
          state_d = sts_i.occ_zero ? S_OUT : S_LIST_RD;
        end else if (!sts_i.hit && sts_i.need_evict) begin
          state_d = S_EVICT;
        end else begin
          state_d = S_OUT;
        end
      end
      S_EVICT:   state_d = S_OUT;
      S_LIST_RD: state_d = S_LIST_OUT;
      S_LIST_OUT: begin
        if (out_ready_i) state_d = sts_i.list_last ? S_IDLE : S_LIST_RD;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.out_sel = OSEL_HIT;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_LOOKUP: begin
        if (sts_i.is_list) begin
          if (sts_i.occ_zero) begin
            cmd_o.out_ld  = 1'b1;
            cmd_o.out_sel = OSEL_EMPTY;
          end else begin
            cmd_o.idx_clr = 1'b1;
            cmd_o.rd_list = 1'b1;
          end
        end else if (sts_i.hit) begin
          cmd_o.out_ld  = 1'b1;
          cmd_o.out_sel = OSEL_HIT;
        end else if (sts_i.need_evict) begin
          cmd_o.rd_oldest = 1'b1;
        end else begin
          cmd_o.append  = 1'b1;
          cmd_o.out_ld  = 1'b1;
          cmd_o.out_sel = OSEL_MISS;
        end
      end
      S_EVICT: begin
        cmd_o.append  = 1'b1;
        cmd_o.evict   = 1'b1;
        cmd_o.out_ld  = 1'b1;
        cmd_o.out_sel = OSEL_MISS;
      end
      S_LIST_RD: begin
        cmd_o.out_ld  = 1'b1;
        cmd_o.out_sel = OSEL_LIST;
      end
      S_LIST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i && !sts_i.list_last) begin
          cmd_o.idx_inc = 1'b1;
          cmd_o.rd_list = 1'b1;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  `FRS_ASSERT(a_ready_excl, clk_i, rst_ni, !(in_ready_o && out_valid_o))
  `FRS_ASSERT(a_idle_ready, clk_i, rst_ni, in_ready_o == (state_q == S_IDLE))
  `FRS_ASSERT_NEXT(a_accept_lookup, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_LOOKUP)

endmodule

// ----- hdl/frs_dp.sv -----
// Datapath for the ID set: CAM compare, FIFO pointers, ID RAM, result register.
// Depends on frs_pkg, frs_ram and fifo_replacement_id_set_macros.svh.
`include "fifo_replacement_id_set_macros.svh"

module frs_dp
  import frs_pkg::*;
#(
  parameter int DEPTH    = 16,
  parameter int ID_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CAP_W-1:0]    cfg_wdata_i,
  input  logic                in_action_i,
  input  logic [IN_ID_W-1:0]  in_sender_id_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [OUT_DW-1:0]   out_tdata_o,
  output logic [OUT_UW-1:0]   out_tuser_o,
  output logic                out_tlast_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);
  localparam int SW = OW + 1;
  localparam int LW = (OW > CAP_W) ? OW : CAP_W;
  localparam int XW = (ID_WIDTH > OUT_ID_W) ? ID_WIDTH : OUT_ID_W;

  function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] sum);
    logic [SW-1:0] red;
    red = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
    return red[AW-1:0];
  endfunction

  logic [ID_WIDTH-1:0] id_q;
  logic                act_q;
  logic [ID_WIDTH-1:0] cam_q [DEPTH];
  logic [DEPTH-1:0]    vld_q, vld_d, match;
  logic [AW-1:0]       oldest_q, oldest_d, wr_slot, rd_slot;
  logic [AW-1:0]       idx_q, idx_d;
  logic [OW-1:0]       occ_q, occ_d, list_off;
  logic [CAP_W-1:0]    cap_q;
  logic [LW-1:0]       limit, cnt_x;
  logic [XW-1:0]       sender_x, ram_x;
  logic [ID_WIDTH-1:0] ram_rdata;

  logic                 hit_q, ev_v_q, ls_v_q, last_q;
  logic [OUT_ID_W-1:0]  ev_id_q, ls_id_q;
  logic [CNT_W-1:0]     cnt_q;

  assign sender_x = XW'(in_sender_id_i);
  assign ram_x    = XW'(ram_rdata);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      id_q  <= sender_x[ID_WIDTH-1:0];
      act_q <= in_action_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(CAP_RST);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      limit = LW'(1);
    end else if (LW'(cap_q) > LW'(DEPTH)) begin
      limit = LW'(DEPTH);
    end else begin
      limit = LW'(cap_q);
    end
  end

  always_comb begin
    for (int s = 0; s < DEPTH; s++) begin
      match[s] = vld_q[s] && (cam_q[s] == id_q);
    end
  end

  assign wr_slot = wrap_slot(SW'(oldest_q) + SW'(occ_q));

  always_comb begin
    vld_d    = vld_q;
    oldest_d = oldest_q;
    occ_d    = occ_q;
    if (cmd_i.append) begin
      if (cmd_i.evict) begin
        vld_d[oldest_q] = 1'b0;
        oldest_d        = wrap_slot(SW'(oldest_q) + SW'(1));
      end else begin
        occ_d = occ_q + OW'(1);
      end
      vld_d[wr_slot] = 1'b1;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end
  end

  assign list_off = occ_q - OW'(1) - OW'(idx_d);
  assign rd_slot  = cmd_i.rd_oldest ? oldest_q : wrap_slot(SW'(oldest_q) + SW'(list_off));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      oldest_q <= '0;
      occ_q    <= '0;
      idx_q    <= '0;
    end else begin
      vld_q    <= vld_d;
      oldest_q <= oldest_d;
      occ_q    <= occ_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      cam_q[wr_slot] <= id_q;
    end
  end

  frs_ram #(
    .WIDTH(ID_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.append),
    .waddr_i(wr_slot),
    .wdata_i(id_q),
    .re_i   (cmd_i.rd_oldest || cmd_i.rd_list),
    .raddr_i(rd_slot),
    .rdata_o(ram_rdata)
  );

  assign sts_o.is_list    = act_q;
  assign sts_o.hit        = |match;
  assign sts_o.occ_zero   = (occ_q == '0);
  assign sts_o.need_evict = (LW'(occ_q) >= limit);
  assign sts_o.list_last  = ((OW'(idx_q) + OW'(1)) == occ_q);

  assign cnt_x = LW'(occ_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      cnt_q   <= cnt_x[CNT_W-1:0];
      hit_q   <= 1'b0;
      ev_v_q  <= 1'b0;
      ev_id_q <= '0;
      ls_v_q  <= 1'b0;
      ls_id_q <= '0;
      last_q  <= 1'b1;
      case (cmd_i.out_sel)
        OSEL_HIT: hit_q <= 1'b1;
        OSEL_MISS: begin
          ev_v_q  <= cmd_i.evict;
          ev_id_q <= cmd_i.evict ? ram_x[OUT_ID_W-1:0] : '0;
        end
        OSEL_LIST: begin
          ls_v_q  <= 1'b1;
          ls_id_q <= ram_x[OUT_ID_W-1:0];
          last_q  <= sts_o.list_last;
        end
        default: last_q <= 1'b1;
      endcase
    end
  end

  assign out_tdata_o = {(OUT_DW - CNT_W - 2 * OUT_ID_W)'(0), cnt_q, ls_id_q, ev_id_q};
  assign out_tuser_o = {ls_v_q, ev_v_q, hit_q};
  assign out_tlast_o = last_q;

  `FRS_ASSERT(a_occ_bound, clk_i, rst_ni, occ_q <= OW'(DEPTH))
  `FRS_ASSERT(a_valid_count, clk_i, rst_ni, $countones(vld_q) == int'(occ_q))
  `FRS_ASSERT_NEXT(a_evict_keeps_occ, clk_i, rst_ni, cmd_i.append && cmd_i.evict, occ_q == $past(occ_q))

endmodule
